@@ rtl/core/lfpd_pkg.sv @@
// Package for the line-follower PD steering block.
// Holds the register indexes, reset values and servo pulse limits.
// No dependencies.
`default_nettype none

package lfpd_pkg;

  localparam int NUM_SENSORS = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_POSITION  = 3'd0,
    CFG_KP_GAIN        = 3'd1,
    CFG_KD_GAIN        = 3'd2,
    CFG_DARK_THRESHOLD = 3'd3,
    CFG_DARK_VALUE     = 3'd4
  } cfg_idx_t;

  localparam logic [13:0] GOAL_RESET      = 14'd2250;
  localparam logic [15:0] KP_RESET        = 16'd1638;
  localparam logic [15:0] KD_RESET        = 16'd197;
  localparam logic [15:0] THRESHOLD_RESET = 16'd1000;
  localparam logic [11:0] DARK_RESET      = 12'd2500;

  localparam logic [10:0] LEFT_BASE  = 11'd1520;
  localparam logic [10:0] LEFT_MIN   = 11'd1490;
  localparam logic [10:0] RIGHT_BASE = 11'd1460;
  localparam logic [10:0] RIGHT_MAX  = 11'd1490;
  // Width of the band between base and limit, in microseconds.
  localparam int          PULSE_SPAN = 30;

  localparam logic signed [15:0] ERR_MAX = 16'sh7FFF;
  localparam logic signed [15:0] ERR_MIN = -16'sh8000;

  // Result of the merge stage, handed to the PD stage.
  typedef struct packed {
    logic               at_int;
    logic signed [15:0] err;
  } merge_res_t;

endpackage

`default_nettype wire

@@ rtl/core/lfpd_sensor_if.sv @@
// Sensor snapshot channel: valid/ready handshake and eight readings.
// Depends on nothing.
`default_nettype none

interface lfpd_sensor_if;
  logic        valid;
  logic        ready;
  logic [15:0] sensor_0;
  logic [15:0] sensor_1;
  logic [15:0] sensor_2;
  logic [15:0] sensor_3;
  logic [15:0] sensor_4;
  logic [15:0] sensor_5;
  logic [15:0] sensor_6;
  logic [15:0] sensor_7;

  modport source (output valid, sensor_0, sensor_1, sensor_2, sensor_3,
                  sensor_4, sensor_5, sensor_6, sensor_7, input ready);
  modport sink (input valid, sensor_0, sensor_1, sensor_2, sensor_3,
                sensor_4, sensor_5, sensor_6, sensor_7, output ready);
endinterface

`default_nettype wire

@@ rtl/core/lfpd_steer_if.sv @@
// Steering result channel: valid/ready handshake, servo pulses and
// PD correction. Depends on nothing.
`default_nettype none

interface lfpd_steer_if;
  logic               valid;
  logic               ready;
  logic [10:0]        left_pulse;
  logic [10:0]        right_pulse;
  logic               at_intersection;
  logic signed [17:0] drive_adjust;

  modport source (output valid, left_pulse, right_pulse, at_intersection,
                  drive_adjust, input ready);
  modport sink (input valid, left_pulse, right_pulse, at_intersection,
                drive_adjust, output ready);
endinterface

`default_nettype wire

@@ rtl/core/line_follow_pd_steering.sv @@
// Line-follower PD steering, top level.
// sensors: sink channel, one snapshot of eight discharge times per
//   transaction, taken when valid and ready are both high.
// steer: source channel, one result per snapshot: left and right servo
//   pulses, intersection flag and the signed PD correction.
// Configuration: cfg_we/cfg_index/cfg_data write goal, kp, kd, dark
//   threshold and dark value; write only while no transaction is in
//   flight.
// Eight lanes test and weight the sensors in parallel; a two-level
// adder merges them into the error; the PD stage multiplies by both
// gains and clamps the pulses.
// Five register stages: lanes, half sums, merge result, products and
// output. Throughput: one snapshot per cycle while steer is not stalled,
// set by the pipelined lanes, adder and multipliers.
// When steer is stalled, each stage holds until the stage after it
// drains, and sensors.ready drops once the pipeline is full.
// Reset clears the pipeline, restores the register defaults and zeroes
// the stored error.
`default_nettype none

module line_follow_pd_steering #(
  parameter int SENSOR_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  lfpd_sensor_if.sink                           sensors,
  lfpd_steer_if.source                          steer,
  input  wire logic                             cfg_we,
  input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [lfpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int VW = (SENSOR_BITS > 12) ? SENSOR_BITS : 12;
  localparam int PW = VW + 3;

  logic [13:0] goal_position;
  logic [15:0] kp_gain;
  logic [15:0] kd_gain;
  logic [15:0] dark_threshold;
  logic [11:0] dark_value;

  logic                  v_lane;
  logic                  en_lane;
  logic                  merge_ready;
  logic                  merge_valid;
  logic                  pd_ready;
  logic [7:0][PW-1:0]    weighted;
  logic [7:0]            dark;
  logic [7:0][15:0]      readings;
  lfpd_pkg::merge_res_t  merge_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      goal_position  <= lfpd_pkg::GOAL_RESET;
      kp_gain        <= lfpd_pkg::KP_RESET;
      kd_gain        <= lfpd_pkg::KD_RESET;
      dark_threshold <= lfpd_pkg::THRESHOLD_RESET;
      dark_value     <= lfpd_pkg::DARK_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lfpd_pkg::CFG_GOAL_POSITION:  goal_position  <= cfg_data[13:0];
        lfpd_pkg::CFG_KP_GAIN:        kp_gain        <= cfg_data;
        lfpd_pkg::CFG_KD_GAIN:        kd_gain        <= cfg_data;
        lfpd_pkg::CFG_DARK_THRESHOLD: dark_threshold <= cfg_data;
        lfpd_pkg::CFG_DARK_VALUE:     dark_value     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    en_lane       = !v_lane || merge_ready;
    sensors.ready = en_lane;
    readings[0]   = sensors.sensor_0;
    readings[1]   = sensors.sensor_1;
    readings[2]   = sensors.sensor_2;
    readings[3]   = sensors.sensor_3;
    readings[4]   = sensors.sensor_4;
    readings[5]   = sensors.sensor_5;
    readings[6]   = sensors.sensor_6;
    readings[7]   = sensors.sensor_7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_lane <= 1'b0;
    end else if (en_lane) begin
      v_lane <= sensors.valid;
    end
  end

  for (genvar g = 0; g < lfpd_pkg::NUM_SENSORS; g++) begin : g_lane
    lfpd_lane #(
      .SENSOR_BITS (SENSOR_BITS),
      .WEIGHT      (g),
      .VW          (VW),
      .PW          (PW)
    ) u_lane (
      .clk            (clk),
      .en             (en_lane),
      .reading        (readings[g]),
      .dark_threshold (dark_threshold),
      .dark_value     (dark_value),
      .weighted       (weighted[g]),
      .dark           (dark[g])
    );
  end

  lfpd_merge #(
    .PW (PW)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (v_lane),
    .in_ready      (merge_ready),
    .weighted      (weighted),
    .dark          (dark),
    .goal_position (goal_position),
    .out_valid     (merge_valid),
    .out_ready     (pd_ready),
    .res           (merge_res)
  );

  lfpd_pd u_pd (
    .clk      (clk),
    .rst      (rst),
    .in_valid (merge_valid),
    .in_ready (pd_ready),
    .res      (merge_res),
    .kp_gain  (kp_gain),
    .kd_gain  (kd_gain),
    .steer    (steer)
  );

endmodule

`default_nettype wire

@@ rtl/core/lfpd_lane.sv @@
// One sensor lane: dark test, dark substitution and weighting by the
// sensor index. Registered output. No package dependency.
`default_nettype none

module lfpd_lane #(
  parameter int SENSOR_BITS = 16,
  parameter int WEIGHT      = 0,
  parameter int VW          = (SENSOR_BITS > 12) ? SENSOR_BITS : 12,
  parameter int PW          = VW + 3
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [15:0]   reading,
  input  wire logic [15:0]   dark_threshold,
  input  wire logic [11:0]   dark_value,
  output logic      [PW-1:0] weighted,
  output logic               dark
);

  logic [15:0]   raw;
  logic          is_dark;
  logic [VW-1:0] value;

  always_comb begin
    raw     = 16'(reading[SENSOR_BITS-1:0]);
    is_dark = raw > dark_threshold;
    value   = is_dark ? VW'(dark_value) : VW'(reading[SENSOR_BITS-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      weighted <= PW'(value) * PW'(WEIGHT);
      dark     <= is_dark;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lfpd_merge.sv @@
// Merge stage: adds the weighted lane values over two registered
// levels, forms the position and the saturated error. Uses lfpd_pkg.
`default_nettype none

module lfpd_merge #(
  parameter int PW = 19
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0][PW-1:0]     weighted,
  input  wire logic [7:0]             dark,
  input  wire logic [13:0]            goal_position,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output lfpd_pkg::merge_res_t        res
);

  localparam int HW = PW + 2;
  localparam int SW = PW + 3;
  localparam int EW = ((PW > 14) ? PW : 14) + 2;

  logic          v_half;
  logic          en_half;
  logic          en_res;
  logic [HW-1:0] half_lo;
  logic [HW-1:0] half_hi;
  logic          all_dark;

  logic [SW-1:0]        sum;
  logic [PW-1:0]        position;
  logic signed [EW-1:0] diff;
  logic signed [15:0]   err_sat;

  always_comb begin
    en_res   = !out_valid || out_ready;
    en_half  = !v_half || en_res;
    in_ready = en_half;

    sum      = SW'(half_lo) + SW'(half_hi);
    position = PW'(sum >> 3);
    diff     = $signed(EW'(goal_position)) - $signed(EW'(position));
    if (diff > EW'(lfpd_pkg::ERR_MAX)) begin
      err_sat = lfpd_pkg::ERR_MAX;
    end else if (diff < EW'(lfpd_pkg::ERR_MIN)) begin
      err_sat = lfpd_pkg::ERR_MIN;
    end else begin
      err_sat = 16'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_half    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_half) begin
        v_half <= in_valid;
      end
      if (en_res) begin
        out_valid <= v_half;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_half) begin
      half_lo  <= HW'(weighted[0]) + HW'(weighted[1]) + HW'(weighted[2])
                + HW'(weighted[3]);
      half_hi  <= HW'(weighted[4]) + HW'(weighted[5]) + HW'(weighted[6])
                + HW'(weighted[7]);
      all_dark <= &dark;
    end
    if (en_res) begin
      res.err    <= err_sat;
      res.at_int <= all_dark;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/lfpd_pd.sv @@
// PD stage: derivative against the stored error, the two gain products,
// truncation toward zero and the clamped servo pulses. Uses lfpd_pkg.
`default_nettype none

module lfpd_pd (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire lfpd_pkg::merge_res_t res,
  input  wire logic [15:0]          kp_gain,
  input  wire logic [15:0]          kd_gain,
  lfpd_steer_if.source              steer
);

  logic                v_prod;
  logic                en_prod;
  logic                en_out;
  logic signed [15:0]  previous_error;
  logic signed [16:0]  err_diff;
  logic signed [33:0]  prod_p;
  logic signed [33:0]  prod_d;
  logic                at_prod;

  logic signed [34:0]  acc;
  logic signed [18:0]  quot;
  logic signed [17:0]  adj;
  logic signed [17:0]  left_sum;
  logic signed [17:0]  right_sum;
  logic [10:0]         left_next;
  logic [10:0]         right_next;

  always_comb begin
    en_out   = !steer.valid || steer.ready;
    en_prod  = !v_prod || en_out;
    in_ready = en_prod;
    err_diff = 17'(res.err) - 17'(previous_error);

    acc  = 35'(prod_p) + 35'(prod_d);
    quot = 19'(acc >>> 16);
    // round toward zero: bump a negative quotient with a nonzero remainder
    if (acc[34] && (acc[15:0] != 16'd0)) begin
      quot = quot + 19'sd1;
    end
    adj = 18'(quot);

    left_sum  = 18'(lfpd_pkg::LEFT_BASE) + adj;
    right_sum = 18'(lfpd_pkg::RIGHT_BASE) + adj;
    if (adj >= 18'sd0) begin
      left_next = lfpd_pkg::LEFT_BASE;
    end else if (adj <= -18'(lfpd_pkg::PULSE_SPAN)) begin
      left_next = lfpd_pkg::LEFT_MIN;
    end else begin
      left_next = 11'(left_sum);
    end
    if (adj <= 18'sd0) begin
      right_next = lfpd_pkg::RIGHT_BASE;
    end else if (adj >= 18'(lfpd_pkg::PULSE_SPAN)) begin
      right_next = lfpd_pkg::RIGHT_MAX;
    end else begin
      right_next = 11'(right_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_prod         <= 1'b0;
      steer.valid    <= 1'b0;
      previous_error <= 16'sd0;
    end else begin
      if (en_prod) begin
        v_prod <= in_valid;
        // advance the stored error as each transaction enters the products
        if (in_valid) begin
          previous_error <= res.err;
        end
      end
      if (en_out) begin
        steer.valid <= v_prod;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_prod) begin
      prod_p  <= $signed({18'd0, kp_gain}) * 34'(res.err);
      prod_d  <= $signed({18'd0, kd_gain}) * 34'(err_diff);
      at_prod <= res.at_int;
    end
    if (en_out) begin
      steer.left_pulse      <= left_next;
      steer.right_pulse     <= right_next;
      steer.at_intersection <= at_prod;
      steer.drive_adjust    <= adj;
    end
  end

endmodule

`default_nettype wire
